// ----- sv/crg_pkg.sv -----
// Shared constants for the circle raster generator.
// No dependencies; used by every module of the block.
package crg_pkg;

  // Default coordinate width (center, radius, offsets)
  localparam int unsigned COORD_WIDTH_DEF = 10;

  // Entries in the step queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Operation codes of an input transaction
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Result index of the final result of one step
  localparam logic [2:0] LAST_IDX_OUTLINE = 3'd7;
  localparam logic [2:0] LAST_IDX_FILL    = 3'd3;

endpackage

// ----- sv/circle_raster_generator_unit.sv -----
// Circle raster generator (Andres rule), top level.
// Instantiates crg_front, crg_queue and crg_back; uses crg_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall): a start transaction (operation 0)
//   loads center, radius and fill mode and gives no result. A step
//   transaction (operation 1) runs one iteration of the circle and gives
//   eight points (outline) or four horizontal spans (fill); a step while
//   no circle is running gives nothing.
//   Result channel (out_valid/out_stall): one point or span per
//   transaction; out_last marks the final result of a step, out_finished
//   marks it too when that step completes the circle.
// Timing:
//   An accepted step job is written into the step queue; the back end then
//   moves its results from the queue head into the output register.
//   The back end emits one result per cycle while out_stall is low; a step
//   gives eight results in outline mode and four in fill mode. A two-entry
//   step queue lets the front keep taking transactions while the back end
//   drains; in_stall rises only when that queue is full.
// Reset (synchronous, rst_n low): idle, queue and output register empty.
// A stalled result holds in the output register, the queue fills, then the
// input channel stalls.
module circle_raster_generator_unit #(
  parameter int unsigned COORD_WIDTH = crg_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic                          in_fill_mode,
  input  logic [COORD_WIDTH-1:0]        in_center_x,
  input  logic [COORD_WIDTH-1:0]        in_center_y,
  input  logic [COORD_WIDTH-1:0]        in_radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH+1:0] out_pos_x,
  output logic signed [COORD_WIDTH+1:0] out_pos_y,
  output logic signed [COORD_WIDTH+1:0] out_span_end_x,
  output logic                          out_last,
  output logic                          out_finished
);

  localparam int unsigned JW = 4 * COORD_WIDTH + 2;

  logic          accept, push, pop, full, head_valid;
  logic [JW-1:0] push_job, head_job;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  crg_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_operation),
    .fill_mode (in_fill_mode),
    .center_x  (in_center_x),
    .center_y  (in_center_y),
    .radius    (in_radius),
    .push      (push),
    .job       (push_job)
  );

  crg_queue #(.DATA_W(JW), .DEPTH(crg_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_data  (head_job)
  );

  crg_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_data      (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_span_end_x (out_span_end_x),
    .out_last       (out_last),
    .out_finished   (out_finished)
  );

endmodule

// ----- sv/crg_front.sv -----
// Front end: accepts transactions, holds circle state and runs the decision rule.
// Pushes one packed step job per active step into the queue. Uses crg_pkg.
module crg_front #(
  parameter int unsigned COORD_WIDTH = crg_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       operation,
  input  logic                       fill_mode,
  input  logic [COORD_WIDTH-1:0]     center_x,
  input  logic [COORD_WIDTH-1:0]     center_y,
  input  logic [COORD_WIDTH-1:0]     radius,
  output logic                       push,
  output logic [4*COORD_WIDTH+1:0]   job
);

  localparam int unsigned DW = COORD_WIDTH + 3;
  localparam int unsigned EW = COORD_WIDTH + 4;

  logic [COORD_WIDTH-1:0] cx_r, cy_r, rad_r, ox_r, oy_r;
  logic [DW-1:0]          dec_r;
  logic                   fill_r, active_r;

  logic signed [EW-1:0] ox_e, oy_e, r_e, d_e;
  logic signed [EW-1:0] ox_nxt, oy_nxt, d_nxt;
  logic                 done;

  always_comb begin
    ox_e = $signed({4'b0000, ox_r});
    oy_e = $signed({4'b0000, oy_r});
    r_e  = $signed({4'b0000, rad_r});
    d_e  = $signed({dec_r[DW-1], dec_r});
    if (d_e >= (ox_e <<< 1)) begin
      d_nxt  = d_e - (ox_e <<< 1) - EW'(1);
      ox_nxt = ox_e + EW'(1);
      oy_nxt = oy_e;
    end else if (d_e < ((r_e - oy_e) <<< 1)) begin
      d_nxt  = d_e + (oy_e <<< 1) - EW'(1);
      ox_nxt = ox_e;
      oy_nxt = oy_e - EW'(1);
    end else begin
      d_nxt  = d_e + ((oy_e - ox_e - EW'(1)) <<< 1);
      ox_nxt = ox_e + EW'(1);
      oy_nxt = oy_e - EW'(1);
    end
    done = oy_nxt < ox_nxt;
  end

  assign push = accept && (operation == crg_pkg::OP_STEP) && active_r;
  assign job  = {fill_r, done, cx_r, cy_r, ox_r, oy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      fill_r   <= 1'b0;
      cx_r     <= '0;
      cy_r     <= '0;
      rad_r    <= '0;
      ox_r     <= '0;
      oy_r     <= '0;
      dec_r    <= '0;
    end else if (accept) begin
      if (operation == crg_pkg::OP_START) begin
        // load a new circle, dropping any running one
        active_r <= 1'b1;
        fill_r   <= fill_mode;
        cx_r     <= center_x;
        cy_r     <= center_y;
        rad_r    <= radius;
        ox_r     <= '0;
        oy_r     <= radius;
        dec_r    <= {3'b000, radius} - {{(DW-1){1'b0}}, 1'b1};
      end else if (active_r) begin
        ox_r  <= ox_nxt[COORD_WIDTH-1:0];
        oy_r  <= oy_nxt[COORD_WIDTH-1:0];
        dec_r <= d_nxt[DW-1:0];
        if (done) begin
          active_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- sv/crg_queue.sv -----
// Small FIFO of step jobs between the front and the back end.
// Register based; depth from crg_pkg by default.
module crg_queue #(
  parameter int unsigned DATA_W = 42,
  parameter int unsigned DEPTH  = crg_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ----- sv/crg_back.sv -----
// Back end: expands the job at the queue head into mirrored points or spans,
// one result per unstalled cycle, through an output register. Uses crg_pkg.
module crg_back #(
  parameter int unsigned COORD_WIDTH = crg_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  logic [4*COORD_WIDTH+1:0]        head_data,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [COORD_WIDTH+1:0]   out_pos_x,
  output logic signed [COORD_WIDTH+1:0]   out_pos_y,
  output logic signed [COORD_WIDTH+1:0]   out_span_end_x,
  output logic                            out_last,
  output logic                            out_finished
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned OW = COORD_WIDTH + 2;

  logic         job_fill, job_done;
  logic [W-1:0] job_cx, job_cy, job_ox, job_oy;

  logic [2:0]  idx_r;
  logic        valid_r;
  logic signed [OW-1:0] px_r, py_r, ex_r;
  logic        last_r, fin_r;

  logic        advance, is_last;
  logic        swap, neg_x, neg_y;
  logic signed [OW-1:0] cx_e, cy_e, dx_e, dy_e, px_nxt, py_nxt, ex_nxt, xplus;

  assign {job_fill, job_done, job_cx, job_cy, job_ox, job_oy} = head_data;

  always_comb begin
    if (job_fill) begin
      swap  = (idx_r[0] == idx_r[1]);
      neg_x = 1'b1;
      neg_y = idx_r[1];
    end else begin
      swap  = idx_r[0];
      neg_x = idx_r[1];
      neg_y = idx_r[2];
    end
    cx_e   = $signed({2'b00, job_cx});
    cy_e   = $signed({2'b00, job_cy});
    dx_e   = $signed({2'b00, swap ? job_oy : job_ox});
    dy_e   = $signed({2'b00, swap ? job_ox : job_oy});
    xplus  = cx_e + dx_e;
    px_nxt = neg_x ? (cx_e - dx_e) : xplus;
    py_nxt = neg_y ? (cy_e - dy_e) : (cy_e + dy_e);
    ex_nxt = job_fill ? xplus : px_nxt;
    is_last = (idx_r == (job_fill ? crg_pkg::LAST_IDX_FILL : crg_pkg::LAST_IDX_OUTLINE));
  end

  // move a result into the output register when it is empty or being taken
  assign advance = head_valid && (!valid_r || !out_stall);
  assign pop     = advance && is_last;

  always_ff @(posedge clk) begin
    if (advance) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      ex_r   <= ex_nxt;
      last_r <= is_last;
      fin_r  <= is_last && job_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (advance) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 3'd0 : idx_r + 3'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = valid_r;
  assign out_pos_x      = px_r;
  assign out_pos_y      = py_r;
  assign out_span_end_x = ex_r;
  assign out_last       = last_r;
  assign out_finished   = fin_r;

endmodule
